>>> design/srgb_pkg.sv
// shared types, constants and helpers for the linear to srgb pixel encoder
// no dependencies; imported by srgb_lane, srgb_alpha and the top level
package srgb_pkg;

	typedef logic signed [19:0] chan_in_t;
	typedef logic [15:0]        chan_out_t;

	// input classes of a colour channel
	typedef enum logic [1:0] {
		CLS_ZERO,
		CLS_FULL,
		CLS_LIN,
		CLS_POW
	} cls_t;

	// side info carried next to the root chains
	typedef struct packed {
		cls_t       cls;
		logic [7:0] lin_x;
	} side_t;

	localparam chan_in_t  ONE_Q16     = 20'sd65536;
	localparam chan_in_t  LIN_LIMIT   = 20'sd205;
	localparam chan_out_t FULL_NARROW = 16'd255;
	localparam chan_out_t FULL_WIDE   = 16'd65535;

	// digit steps of the root units
	localparam int SQ_STEPS   = 32;
	localparam int CB_STEPS   = 21;
	localparam int SQ6_STEPS  = 21;
	localparam int ROOT_STAGES = 2 * SQ_STEPS;
	localparam int B_PAD      = ROOT_STAGES - CB_STEPS - SQ6_STEPS;

	// input capture, root chain, then product, offset, scale, divide, clamp
	localparam int LANE_LAT = 1 + ROOT_STAGES + 5;

	// curve constants
	localparam logic [42:0] POW_GAIN   = 43'd1055;
	localparam logic [42:0] POW_OFFSET = 43'h370_0000_00 << 4;
	localparam logic [21:0] LIN_GAIN   = 22'd12920;

	// floor(q / 1000) as (q * DIV_M) >> DIV_K, exact for q below 2^26
	localparam logic [26:0] DIV_M = 27'd68719477;
	localparam int          DIV_K = 36;
	localparam int          QUO_W = 17;

	function automatic chan_out_t full_scale(input logic wide);
		return wide ? FULL_WIDE : FULL_NARROW;
	endfunction

endpackage

>>> design/srgb_lane.sv
// one colour lane of the srgb encoder: pipelined digit roots and output scaling
// depends on srgb_pkg
module srgb_lane
	import srgb_pkg::*;
(
	input  logic      clk,
	input  logic      wide,
	input  chan_in_t  chan_in,
	output chan_out_t chan_out
);

	cls_t        cls_c;
	cls_t        cls_s1;
	logic [15:0] ux_s1;

	always_comb begin
		if (chan_in <= 20'sd0) begin
			cls_c = CLS_ZERO;
		end else if (chan_in >= ONE_Q16) begin
			cls_c = CLS_FULL;
		end else if (chan_in <= LIN_LIMIT) begin
			cls_c = CLS_LIN;
		end else begin
			cls_c = CLS_POW;
		end
	end

	always_ff @(posedge clk) begin
		cls_s1 <= cls_c;
		ux_s1  <= chan_in[15:0];
	end

	// chain a, first root: sqrt(x << 48), one bit per stage
	logic [15:0] sqa_rad_s  [SQ_STEPS];
	logic [32:0] sqa_rem_s  [SQ_STEPS];
	logic [31:0] sqa_root_s [SQ_STEPS];

	for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sqa
		logic [15:0] rad_p;
		logic [32:0] rem_p;
		logic [31:0] root_p;
		logic [34:0] tmp;
		logic [34:0] trial;
		logic        take;
		if (i == 0) begin : g_first
			assign rad_p  = ux_s1;
			assign rem_p  = '0;
			assign root_p = '0;
		end else begin : g_next
			assign rad_p  = sqa_rad_s[i-1];
			assign rem_p  = sqa_rem_s[i-1];
			assign root_p = sqa_root_s[i-1];
		end
		assign tmp   = {rem_p, rad_p[15:14]};
		assign trial = {1'b0, root_p, 2'b01};
		assign take  = tmp >= trial;
		always_ff @(posedge clk) begin
			sqa_rad_s[i]  <= {rad_p[13:0], 2'b00};
			sqa_rem_s[i]  <= take ? 33'(tmp - trial) : tmp[32:0];
			sqa_root_s[i] <= {root_p[30:0], take};
		end
	end

	// chain a, second root: sqrt(r << 32) gives the fourth root in q32
	logic [31:0] sqb_rad_s  [SQ_STEPS];
	logic [32:0] sqb_rem_s  [SQ_STEPS];
	logic [31:0] sqb_root_s [SQ_STEPS];

	for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sqb
		logic [31:0] rad_p;
		logic [32:0] rem_p;
		logic [31:0] root_p;
		logic [34:0] tmp;
		logic [34:0] trial;
		logic        take;
		if (i == 0) begin : g_first
			assign rad_p  = sqa_root_s[SQ_STEPS-1];
			assign rem_p  = '0;
			assign root_p = '0;
		end else begin : g_next
			assign rad_p  = sqb_rad_s[i-1];
			assign rem_p  = sqb_rem_s[i-1];
			assign root_p = sqb_root_s[i-1];
		end
		assign tmp   = {rem_p, rad_p[31:30]};
		assign trial = {1'b0, root_p, 2'b01};
		assign take  = tmp >= trial;
		always_ff @(posedge clk) begin
			sqb_rad_s[i]  <= {rad_p[29:0], 2'b00};
			sqb_rem_s[i]  <= take ? 33'(tmp - trial) : tmp[32:0];
			sqb_root_s[i] <= {root_p[30:0], take};
		end
	end

	// chain b, cube root of x << 47, square of the partial root kept alongside
	logic [17:0] cb_rad_s [CB_STEPS];
	logic [43:0] cb_rem_s [CB_STEPS];
	logic [20:0] cb_y_s   [CB_STEPS];
	logic [41:0] cb_sq_s  [CB_STEPS];

	for (genvar i = 0; i < CB_STEPS; i++) begin : g_cb
		logic [17:0] rad_p;
		logic [43:0] rem_p;
		logic [20:0] y_p;
		logic [41:0] sq_p;
		logic [46:0] tmp;
		logic [46:0] bnd;
		logic        take;
		if (i == 0) begin : g_first
			assign rad_p = {ux_s1, 2'b00};
			assign rem_p = '0;
			assign y_p   = '0;
			assign sq_p  = '0;
		end else begin : g_next
			assign rad_p = cb_rad_s[i-1];
			assign rem_p = cb_rem_s[i-1];
			assign y_p   = cb_y_s[i-1];
			assign sq_p  = cb_sq_s[i-1];
		end
		assign tmp = {rem_p, rad_p[17:15]};
		// 3 * 2y * (2y + 1) + 1
		assign bnd = 47'({sq_p, 3'b000}) + 47'({sq_p, 2'b00}) + 47'({y_p, 2'b00})
			+ 47'({y_p, 1'b0}) + 47'd1;
		assign take = tmp >= bnd;
		always_ff @(posedge clk) begin
			cb_rad_s[i] <= {rad_p[14:0], 3'b000};
			cb_rem_s[i] <= take ? 44'(tmp - bnd) : tmp[43:0];
			cb_y_s[i]   <= {y_p[19:0], take};
			cb_sq_s[i]  <= take ? 42'({sq_p, 2'b00} + 44'({y_p, 2'b00}) + 44'd1)
				: {sq_p[39:0], 2'b00};
		end
	end

	// chain b, sqrt(c << 21) gives the sixth root in q21
	logic [21:0] sq6_rad_s  [SQ6_STEPS];
	logic [21:0] sq6_rem_s  [SQ6_STEPS];
	logic [20:0] sq6_root_s [SQ6_STEPS];

	for (genvar i = 0; i < SQ6_STEPS; i++) begin : g_sq6
		logic [21:0] rad_p;
		logic [21:0] rem_p;
		logic [20:0] root_p;
		logic [23:0] tmp;
		logic [23:0] trial;
		logic        take;
		if (i == 0) begin : g_first
			assign rad_p  = {cb_y_s[CB_STEPS-1], 1'b0};
			assign rem_p  = '0;
			assign root_p = '0;
		end else begin : g_next
			assign rad_p  = sq6_rad_s[i-1];
			assign rem_p  = sq6_rem_s[i-1];
			assign root_p = sq6_root_s[i-1];
		end
		assign tmp   = {rem_p, rad_p[21:20]};
		assign trial = {1'b0, root_p, 2'b01};
		assign take  = tmp >= trial;
		always_ff @(posedge clk) begin
			sq6_rad_s[i]  <= {rad_p[19:0], 2'b00};
			sq6_rem_s[i]  <= take ? 22'(tmp - trial) : tmp[21:0];
			sq6_root_s[i] <= {root_p[19:0], take};
		end
	end

	// chain b is shorter, pad it to line up with chain a
	logic [20:0] pad_s [B_PAD];

	for (genvar i = 0; i < B_PAD; i++) begin : g_pad
		if (i == 0) begin : g_first
			always_ff @(posedge clk) begin
				pad_s[i] <= sq6_root_s[SQ6_STEPS-1];
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				pad_s[i] <= pad_s[i-1];
			end
		end
	end

	// class and linear input ride along the roots
	side_t side_s [ROOT_STAGES];

	for (genvar i = 0; i < ROOT_STAGES; i++) begin : g_side
		if (i == 0) begin : g_first
			always_ff @(posedge clk) begin
				side_s[i] <= '{cls: cls_s1, lin_x: ux_s1[7:0]};
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				side_s[i] <= side_s[i-1];
			end
		end
	end

	// x^(5/12) in q32
	logic [31:0] r6_c;
	logic [63:0] prod_c;
	logic [31:0] p_s66;
	side_t       side_s66;

	assign r6_c   = {pad_s[B_PAD-1], 11'b0};
	assign prod_c = 64'(sqb_root_s[SQ_STEPS-1]) * 64'(r6_c);

	always_ff @(posedge clk) begin
		p_s66    <= prod_c[63:32];
		side_s66 <= side_s[ROOT_STAGES-1];
	end

	// numerator over 1000 * 2^32, linear segment mapped onto the same scale
	logic [42:0] pw_c;
	logic [21:0] lin_prod_c;
	logic [41:0] lin_c;
	logic [41:0] num_c;
	logic [41:0] num_s67;
	logic        full_s67;

	assign pw_c       = 43'(p_s66) * POW_GAIN;
	assign lin_prod_c = 22'(side_s66.lin_x) * LIN_GAIN;
	assign lin_c      = 42'({lin_prod_c, 16'h0000});

	always_comb begin
		case (side_s66.cls)
			CLS_POW: num_c = (pw_c > POW_OFFSET) ? 42'(pw_c - POW_OFFSET) : '0;
			CLS_LIN: num_c = lin_c;
			default: num_c = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		num_s67  <= num_c;
		full_s67 <= (side_s66.cls == CLS_FULL);
	end

	// times full scale as shift and subtract, then drop 32 fraction bits
	logic [57:0] scaled_c;
	logic [25:0] q_s68;
	logic        full_s68;

	assign scaled_c = wide ? (58'({num_s67, 16'h0000}) - 58'(num_s67))
		: (58'({num_s67, 8'h00}) - 58'(num_s67));

	always_ff @(posedge clk) begin
		q_s68    <= scaled_c[57:32];
		full_s68 <= full_s67;
	end

	// divide by 1000 through the reciprocal
	logic [52:0]      qm_c;
	logic [QUO_W-1:0] quo_s69;
	logic             full_s69;

	assign qm_c = 53'(q_s68) * 53'(DIV_M);

	always_ff @(posedge clk) begin
		quo_s69  <= qm_c[DIV_K +: QUO_W];
		full_s69 <= full_s68;
	end

	// clamp to full scale
	chan_out_t fs_c;

	assign fs_c = full_scale(wide);

	always_ff @(posedge clk) begin
		if (full_s69 || (quo_s69 > QUO_W'(fs_c))) begin
			chan_out <= fs_c;
		end else begin
			chan_out <= quo_s69[15:0];
		end
	end

endmodule

>>> design/srgb_alpha.sv
// alpha lane: linear scale to full scale with clamp, delayed to match the colour lanes
// depends on srgb_pkg
module srgb_alpha
	import srgb_pkg::*;
(
	input  logic      clk,
	input  logic      wide,
	input  chan_in_t  alpha_in,
	output chan_out_t alpha_out
);

	logic [15:0] ux_c;
	logic [31:0] prod_c;
	chan_out_t   scaled_c;
	chan_out_t   al_s [LANE_LAT];

	assign ux_c   = alpha_in[15:0];
	assign prod_c = wide ? ({ux_c, 16'h0000} - 32'(ux_c))
		: (32'({ux_c, 8'h00}) - 32'(ux_c));

	always_comb begin
		if (alpha_in <= 20'sd0) begin
			scaled_c = '0;
		end else if (alpha_in >= ONE_Q16) begin
			scaled_c = full_scale(wide);
		end else begin
			scaled_c = prod_c[31:16];
		end
	end

	for (genvar i = 0; i < LANE_LAT; i++) begin : g_dly
		if (i == 0) begin : g_first
			always_ff @(posedge clk) begin
				al_s[i] <= scaled_c;
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				al_s[i] <= al_s[i-1];
			end
		end
	end

	assign alpha_out = al_s[LANE_LAT-1];

endmodule

>>> design/linear_to_srgb_pixel.sv
// top level of the linear to srgb pixel encoder: mode register, beat tracking, lanes
// depends on srgb_pkg, srgb_lane and srgb_alpha
//
// Takes one RGBA pixel per clock in signed Q3.16 and returns its sRGB codes
// from the pipelined lanes, one beat per pixel in order. busy is
// always low, so every cycle with start high is an accepted beat, back to back
// without gaps. The result sits on the output ports for the single cycle that
// done is high; there is no back pressure, so the receiver must take it then.
// Latency is set by the colour root chain: two 32-step square roots in series,
// one result bit per stage, followed by five stages of product, offset,
// scaling, divide by 1000 and clamp. output_wide (reset 0) picks 8-bit codes
// (0..255, upper byte zero) or 16-bit codes (0..65535); write it only while no
// pixel is in flight.
module linear_to_srgb_pixel
	import srgb_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  chan_in_t  red_in,
	input  chan_in_t  green_in,
	input  chan_in_t  blue_in,
	input  chan_in_t  alpha_in,
	input  logic      cfg_wr_en,
	input  logic      cfg_wr_data,
	output logic      done,
	output chan_out_t red_out,
	output chan_out_t green_out,
	output chan_out_t blue_out,
	output chan_out_t alpha_out
);

	logic                output_wide_q;
	logic                accept;
	logic [LANE_LAT-1:0] vld_q;

	// fully pipelined, never holds off a beat
	assign busy   = 1'b0;
	assign accept = start & ~busy;

	// mode register, only bit 0 exists
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			output_wide_q <= 1'b0;
		end else if (cfg_wr_en) begin
			output_wide_q <= cfg_wr_data;
		end
	end

	// one valid bit per pipeline stage, its tail is the result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LANE_LAT-2:0], accept};
		end
	end

	assign done = vld_q[LANE_LAT-1];

	// three colour lanes run the transfer curve side by side
	srgb_lane u_lane_red (
		.clk      (clk),
		.wide     (output_wide_q),
		.chan_in  (red_in),
		.chan_out (red_out)
	);

	srgb_lane u_lane_green (
		.clk      (clk),
		.wide     (output_wide_q),
		.chan_in  (green_in),
		.chan_out (green_out)
	);

	srgb_lane u_lane_blue (
		.clk      (clk),
		.wide     (output_wide_q),
		.chan_in  (blue_in),
		.chan_out (blue_out)
	);

	// alpha skips the curve, delayed to land with the colour codes
	srgb_alpha u_alpha (
		.clk       (clk),
		.wide      (output_wide_q),
		.alpha_in  (alpha_in),
		.alpha_out (alpha_out)
	);

endmodule
